// ===== hdl/salru_pkg.sv =====
// Shared types and fixed geometry of the set-associative LRU cache with line lifetimes.
package salru_pkg;

  localparam int unsigned ADDR_W  = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TTL_W   = 9;
  localparam int unsigned TICK_W  = 48;

  localparam int unsigned LINES   = 64;
  localparam int unsigned WAYS    = 4;
  localparam int unsigned WORDS   = 4;
  localparam int unsigned SETS    = LINES / WAYS;

  localparam int unsigned OFF_W   = $clog2(WORDS);
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned SET_LO  = OFF_W + WAY_W;
  localparam int unsigned TAG_LO  = OFF_W + $clog2(LINES);
  localparam int unsigned TAG_W   = ADDR_W - TAG_LO;

  localparam logic [TTL_W-1:0] TTL_RESET = 9'd300;

  typedef struct packed {
    logic        [ADDR_W-1:0] request_address;
    logic signed [DATA_W-1:0] fill_data;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     hit;
    logic        [CNT_W-1:0]  hit_total;
    logic        [CNT_W-1:0]  miss_total;
  } rsp_t;

  // One way of a set: fill stamp and lifetime stand in for a per-line countdown.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
    logic [TICK_W-1:0] stamp;
    logic [TTL_W-1:0]  life;
  } line_t;

  typedef line_t [WAYS-1:0] set_t;

  // Recency list of a set, entry 0 least recent.
  typedef logic [WAYS-1:0][WAY_W-1:0] order_t;

endpackage

// ===== hdl/salru_ram.sv =====
// Generic simple dual-port RAM with registered read.
module salru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/set_assoc_lru_ttl_cache_core.sv =====
// Top level of the four-way set-associative read cache with true LRU and line lifetimes.
//
// Usage:
//   Request channel: drive in_req (word address and the backing store word) and
//   raise start; the word is taken at the edge where start is high and busy low.
//   Result channel: out_valid is high for exactly one cycle with out_rsp (word
//   returned, hit flag, running hit and miss totals). The receiver cannot stall,
//   so nothing is ever held back on this side.
//   Configuration: cfg_data is the lifetime loaded into newly filled lines; it is
//   written when cfg_valid and cfg_ready are both high. cfg_ready is always high.
//   Zero means filled lines never expire.
//
// Timing: an accepted word passes the lookup and update states, and busy
// stays high until the block is idle again. The pass is a read-modify-write
// over the set memory: read the set, compare tags and ages, then write back
// the victim and update the LRU list. The registered result strobe is high in
// the cycle in which the next word may already be accepted.
//
// Reset: valid bits, LRU lists, counters, the access tick and the lifetime
// register (300) are set at once; the memory needs no clearing pass.
module set_assoc_lru_ttl_cache_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  salru_pkg::req_t               in_req,
  output logic                          out_valid,
  output salru_pkg::rsp_t               out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [salru_pkg::TTL_W-1:0]   cfg_data
);

  import salru_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  req_t                     req_r;
  logic [WAYS-1:0]          hit_vec_r, hit_vec;
  order_t                   rec_r [SETS];
  logic [SETS-1:0][WAYS-1:0] vld_r;
  logic [CNT_W-1:0]         hit_cnt_r, miss_cnt_r;
  logic [TICK_W-1:0]        tick_r;
  logic [TTL_W-1:0]         ttl_r;
  logic                     out_valid_r;
  rsp_t                     out_rsp_r;

  logic                     accept;
  logic [SET_W-1:0]         in_set, set_r;
  logic [TAG_W-1:0]         tag_r;
  set_t                     rd_set, wr_set;
  logic                     wr_en;
  logic [TICK_W-1:0]        age [WAYS];

  logic                     found;
  logic [WAY_W-1:0]         hit_way, victim, touch_way;
  logic [WAY_W-1:0]         pos;
  order_t                   order_cur, order_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_set = in_req.request_address[SET_LO +: SET_W];
  assign set_r  = req_r.request_address[SET_LO +: SET_W];
  assign tag_r  = req_r.request_address[TAG_LO +: TAG_W];

  // Set memory: all ways of one set per entry, read on accept, written on a miss.
  salru_ram #(
    .WIDTH ($bits(set_t)),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_r),
    .wdata (wr_set),
    .re    (accept),
    .raddr (in_set),
    .rdata (rd_set)
  );

  // Tag and age compare. A line is live while fewer accesses than its lifetime
  // have passed since the access that filled it; a lifetime of zero never ages out.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      age[w]     = tick_r - rd_set[w].stamp;
      hit_vec[w] = vld_r[set_r][w] && (rd_set[w].tag == tag_r) &&
                   ((rd_set[w].life == '0) || (age[w] < TICK_W'(rd_set[w].life)));
    end
  end

  // Update pass: pick the way to touch, move it to the recent end of the list and build the set written back on a miss.
  always_comb begin
    found     = |hit_vec_r;
    hit_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_vec_r[w]) begin
        hit_way = WAY_W'(w);
      end
    end
    order_cur = rec_r[set_r];
    victim    = order_cur[0];
    touch_way = found ? hit_way : victim;
    pos       = '0;
    for (int k = 0; k < WAYS; k++) begin
      if (order_cur[k] == touch_way) begin
        pos = WAY_W'(k);
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      if (k < int'(pos)) begin
        order_nxt[k] = order_cur[k];
      end else if (k < WAYS - 1) begin
        order_nxt[k] = order_cur[k + 1];
      end else begin
        order_nxt[k] = touch_way;
      end
    end

    wr_set               = rd_set;
    wr_set[victim].tag   = tag_r;
    wr_set[victim].data  = req_r.fill_data;
    wr_set[victim].stamp = tick_r;
    wr_set[victim].life  = ttl_r;
    wr_en                = (state_r == ST_UPD) && !found;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == ST_LOOK) begin
      hit_vec_r <= hit_vec;
    end
    if (state_r == ST_UPD) begin
      out_rsp_r.read_data  <= found ? signed'(rd_set[hit_way].data) : req_r.fill_data;
      out_rsp_r.hit        <= found;
      out_rsp_r.hit_total  <= found ? hit_cnt_r + 1'b1 : hit_cnt_r;
      out_rsp_r.miss_total <= found ? miss_cnt_r : miss_cnt_r + 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      tick_r      <= '0;
      ttl_r       <= TTL_RESET;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          rec_r[s][w] <= WAY_W'(w);
        end
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPD);
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_data;
      end
      if (state_r == ST_UPD) begin
        rec_r[set_r] <= order_nxt;
        tick_r       <= tick_r + 1'b1;
        if (found) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_r           <= miss_cnt_r + 1'b1;
          vld_r[set_r][victim] <= 1'b1;
        end
      end
    end
  end

  // An accepted word always starts a pass.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not start a pass");

  // A result strobe only follows the update pass.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_UPD)
    else $error("result strobe without an update pass");

  // At most one live way of a set matches a tag.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(hit_vec_r))
    else $error("several ways hit at once");

  // Each result advances the hit and miss totals by exactly one between them.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CNT_W'(out_rsp.hit_total + out_rsp.miss_total) ==
                   CNT_W'($past(hit_cnt_r) + $past(miss_cnt_r) + 1'b1)))
    else $error("totals did not advance by one");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the four-way LRU read cache with line lifetimes.
module tb_top;
  import salru_pkg::*;

  // Generous run ceiling, well above the length of the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // Settling slack when draining, after the last awaited result is in.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned TAG_POOL      = 6;
  localparam int unsigned MAX_PRINTS    = 40;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  req_t             in_req;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [TTL_W-1:0] cfg_data;

  set_assoc_lru_ttl_cache_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the cache contents, kept as a plain per-line countdown.
  logic              shadow_valid [SETS][WAYS];
  logic [TAG_W-1:0]  shadow_tag   [SETS][WAYS];
  logic [DATA_W-1:0] shadow_word  [SETS][WAYS];
  logic [TTL_W-1:0]  shadow_life  [SETS][WAYS];
  logic [WAY_W-1:0]  lru_list     [SETS][WAYS];  // entry 0 is least recent
  logic [CNT_W-1:0]  hits_so_far;
  logic [CNT_W-1:0]  misses_so_far;
  logic [TTL_W-1:0]  fill_life;

  rsp_t              awaited_lookups [$];
  int unsigned       mismatch_count;
  int unsigned       words_sent;
  int unsigned       ttl_writes;
  int unsigned       cycle_count;
  logic [TAG_W-1:0]  tag_pool [TAG_POOL];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the traffic never completes.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Rotate the way held at position pos to the most recent end of the list.
  function automatic void move_to_mru(int unsigned s, int unsigned pos);
    logic [WAY_W-1:0] w;
    int unsigned      k;
    w = lru_list[s][pos];
    for (k = pos; k < WAYS - 1; k++)
      lru_list[s][k] = lru_list[s][k + 1];
    lru_list[s][WAYS - 1] = w;
  endfunction

  // Work out the result of one lookup and advance the shadow state with it.
  function automatic rsp_t predict_lookup(req_t r);
    int unsigned      line_no;
    int unsigned      s;
    int unsigned      w;
    int unsigned      hit_way;
    int unsigned      pos;
    int unsigned      ss;
    int unsigned      ww;
    logic [TAG_W-1:0] t;
    rsp_t             o;
    line_no = r.request_address / WORDS;
    s       = (line_no % LINES) / WAYS;
    t       = TAG_W'(line_no / LINES);
    hit_way = WAYS;
    for (w = 0; w < WAYS; w++)
      if (hit_way == WAYS && shadow_valid[s][w] && shadow_tag[s][w] == t)
        hit_way = w;
    o.hit = (hit_way != WAYS);
    if (o.hit) begin
      hits_so_far++;
      o.read_data = shadow_word[s][hit_way];
      pos = 0;
      for (w = 0; w < WAYS; w++)
        if (lru_list[s][w] == hit_way)
          pos = w;
      move_to_mru(s, pos);
    end else begin
      // The victim is always the least recent way, even if another is invalid.
      w = 32'(lru_list[s][0]);
      misses_so_far++;
      shadow_valid[s][w] = 1'b1;
      shadow_tag[s][w]   = t;
      shadow_word[s][w]  = r.fill_data;
      shadow_life[s][w]  = fill_life;
      move_to_mru(s, 0);
      o.read_data = r.fill_data;
    end
    // One tick of ageing after every access; a life of zero never counts.
    for (ss = 0; ss < SETS; ss++)
      for (ww = 0; ww < WAYS; ww++)
        if (shadow_valid[ss][ww] && shadow_life[ss][ww] != '0) begin
          shadow_life[ss][ww]--;
          if (shadow_life[ss][ww] == '0)
            shadow_valid[ss][ww] = 1'b0;
        end
    o.hit_total  = hits_so_far;
    o.miss_total = misses_so_far;
    return o;
  endfunction

  // Result side: the block cannot be held off, so check every strobed word.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid) begin
      if (awaited_lookups.size() == 0) begin
        flag_mismatch("result word with no request outstanding");
      end else begin
        want = awaited_lookups.pop_front();
        if (out_rsp.read_data !== want.read_data)
          flag_mismatch($sformatf("read_data %h, expected %h",
                                  out_rsp.read_data, want.read_data));
        if (out_rsp.hit !== want.hit)
          flag_mismatch($sformatf("hit %b, expected %b", out_rsp.hit, want.hit));
        if (out_rsp.hit_total !== want.hit_total)
          flag_mismatch($sformatf("hit_total %0d, expected %0d",
                                  out_rsp.hit_total, want.hit_total));
        if (out_rsp.miss_total !== want.miss_total)
          flag_mismatch($sformatf("miss_total %0d, expected %0d",
                                  out_rsp.miss_total, want.miss_total));
      end
    end
  end

  // Send one request word. Hold start low for a random gap first, then keep it
  // high until the block takes the word. Start is left high afterwards so that
  // a following word can go out back to back without a dip.
  task automatic send_word(req_t r, int unsigned gap_pct);
    rsp_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    predicted       = predict_lookup(r);
    awaited_lookups = {awaited_lookups, predicted};
    words_sent++;
  endtask

  // Drop start, wait for every outstanding result and let the pipeline settle.
  task automatic drain_block();
    int unsigned k;
    start <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && awaited_lookups.size() != 0; k++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the lifetime register; only ever done with the block idle.
  task automatic set_fill_life(logic [TTL_W-1:0] v);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fill_life = v;
    ttl_writes++;
  endtask

  function automatic req_t word_of(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    req_t r;
    r.request_address = addr;
    r.fill_data       = data;
    return r;
  endfunction

  function automatic req_t random_word();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)
      r.request_address = ADDR_W'($urandom);
    else if (pick < 10)
      r.request_address = pick[0] ? '1 : '0;
    else
      // Mostly a small pool of tags, so lines get reused and hit.
      r.request_address = {tag_pool[$urandom_range(TAG_POOL - 1)], SET_W'($urandom),
                           (ADDR_W - TAG_W - SET_W)'($urandom)};
    r.fill_data = $urandom;
    return r;
  endfunction

  // Random traffic at one lifetime setting. The first 16 words of every 64
  // go back to back, so there are stretches without gaps in every phase.
  task automatic run_traffic(int unsigned n, int unsigned gap_pct, logic [TTL_W-1:0] ttl);
    int unsigned i;
    set_fill_life(ttl);
    for (i = 0; i < TAG_POOL; i++)
      tag_pool[i] = TAG_W'($urandom);
    for (i = 0; i < n; i++)
      send_word(random_word(), (i % 64 < 16) ? 0 : gap_pct);
  endtask

  // Address extremes, same-line offsets and fill data extremes, at reset lifetime.
  task automatic test_extremes();
    send_word(word_of('0, 32'h7FFF_FFFF), 0);
    send_word(word_of(31'h0000_0003, 32'h0000_0000), 0);
    send_word(word_of('1, 32'h8000_0000), 0);
    send_word(word_of(31'h7FFF_FFFC, 32'hFFFF_FFFF), 0);
    send_word(word_of(31'h0000_0100, 32'hFFFF_FFFF), 0);
    send_word(word_of('0, 32'h1234_5678), 0);
  endtask

  // A line filled with a life of one is gone by the next access.
  task automatic test_life_of_one();
    set_fill_life(9'd1);
    send_word(word_of(31'h0000_0030, 32'hA5A5_0001), 0);
    send_word(word_of(31'h0000_0030, 32'hA5A5_0002), 0);
    send_word(word_of(31'h0000_0034, 32'hA5A5_0003), 0);
  endtask

  // Fill three ways of set nine for good, let the fourth expire at once, then
  // miss again: the least recent valid way goes, not the invalid one.
  task automatic test_lru_victim();
    set_fill_life('0);
    send_word(word_of(31'h0000_0190, 32'h1111_1111), 0);
    send_word(word_of(31'h0000_0290, 32'h2222_2222), 0);
    send_word(word_of(31'h0000_0390, 32'h3333_3333), 0);
    set_fill_life(9'd1);
    send_word(word_of(31'h0000_0490, 32'h4444_4444), 0);
    set_fill_life('0);
    send_word(word_of(31'h0000_0590, 32'h5555_5555), 0);
    send_word(word_of(31'h0000_0194, 32'h6666_6666), 0);
    send_word(word_of(31'h0000_0398, 32'h7777_7777), 0);
    send_word(word_of(31'h0000_059C, 32'h8888_8888), 0);
  endtask

  task automatic test_streaming();
    run_traffic(360, 0, TTL_RESET);
  endtask

  task automatic test_sender_gaps();
    run_traffic(360, 78, '1);
  endtask

  // Short lifetimes make expiry frequent; the result side has no stall to apply.
  task automatic test_short_lives();
    run_traffic(360, 0, TTL_W'($urandom_range(40, 2)));
  endtask

  task automatic test_mixed_gaps();
    run_traffic(360, 29, '0);
  endtask

  initial begin
    int unsigned s;
    int unsigned w;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_req    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    for (s = 0; s < SETS; s++)
      for (w = 0; w < WAYS; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_tag[s][w]   = '0;
        shadow_word[s][w]  = '0;
        shadow_life[s][w]  = '0;
        lru_list[s][w]     = WAY_W'(w);
      end
    hits_so_far    = '0;
    misses_so_far  = '0;
    fill_life      = TTL_RESET;
    mismatch_count = 0;
    words_sent     = 0;
    ttl_writes     = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_life_of_one();
    test_lru_victim();
    test_streaming();
    test_sender_gaps();
    test_short_lives();
    test_mixed_gaps();

    drain_block();
    if (awaited_lookups.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_lookups.size()));

    $display("Covered %0d request words: %0d hits, %0d misses, %0d lifetime writes,",
             words_sent, hits_so_far, misses_so_far, ttl_writes);
    $display("with back-to-back and gapped traffic, expiry, LRU victims and address extremes.");
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/salru_pkg.sv
hdl/salru_ram.sv
hdl/set_assoc_lru_ttl_cache_core.sv
tb/tb_top.sv
